FILE: rtl/sbtm_pkg.sv
// ----------------------------------------------------------------------------
// sbtm_pkg: shared types and constants of the switch block track mapper
// Word layouts of the channels, side and pattern codes, register indexes.
// ----------------------------------------------------------------------------
package sbtm_pkg;

  localparam int TRACK_W = 10;  // source/dest track index
  localparam int COUNT_W = 11;  // destination track count
  localparam int FLEX_W  = 6;   // flexibility register
  localparam int RUNS_W  = 5;   // results per word
  localparam int STEP_W  = 2;   // 3 mod n
  localparam int IDX_W   = 2;   // configuration register index

  localparam int MAX_TRACKS = 1024;
  localparam int MAX_FLEX   = 48;

  // floor(x / 3) = (x * 43) >> 7 for any six-bit x
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;
  localparam int DIV3_W     = 12;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  localparam logic [1:0] PAT_SUBSET    = 2'd0;
  localparam logic [1:0] PAT_UNIVERSAL = 2'd1;
  localparam logic [1:0] PAT_WILTON    = 2'd2;

  localparam logic [IDX_W-1:0] CFG_PATTERN = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FLEX    = 2'd1;

  localparam logic [1:0]        PATTERN_RST = PAT_WILTON;
  localparam logic [FLEX_W-1:0] FLEX_RST    = 6'd3;

  typedef struct packed {
    logic [1:0]         source_side;
    logic [TRACK_W-1:0] source_track;
    logic [1:0]         dest_side;
    logic [COUNT_W-1:0] dest_count;
  } in_word_t;

  typedef struct packed {
    logic [TRACK_W-1:0] dest_track;
    logic               no_connection;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  reg_index;
    logic [FLEX_W-1:0] wdata;
  } cfg_word_t;

  // word travelling along the modulo cells
  typedef struct packed {
    logic [1:0]         source_side;
    logic [1:0]         dest_side;
    logic [COUNT_W-1:0] n;
    logic [TRACK_W-1:0] rem;
  } cell_word_t;

  // job handed to the emitter
  typedef struct packed {
    logic [TRACK_W-1:0] base;
    logic [COUNT_W-1:0] n;
    logic [STEP_W-1:0]  step;
    logic [RUNS_W-1:0]  runs;
    logic               no_connection;
  } job_t;

endpackage

FILE: rtl/sbtm_stream_if.sv
// ----------------------------------------------------------------------------
// sbtm_stream_if: valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface sbtm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sbtm_mod_cell.sv
// ----------------------------------------------------------------------------
// sbtm_mod_cell: one restoring step of track mod count
// Subtracts n << SHIFT from the running remainder when it fits.
// ----------------------------------------------------------------------------
module sbtm_mod_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  sbtm_stream_if.sink    up,
  sbtm_stream_if.source  dn
);

  localparam int W = sbtm_pkg::TRACK_W + sbtm_pkg::COUNT_W;

  logic                   v_r, v_nxt;
  sbtm_pkg::cell_word_t   d_r, d_nxt;
  logic [W-1:0]           rem_w;
  logic [W-1:0]           div_w;
  logic                   load;

  assign up.ready = !v_r || dn.ready;
  assign load     = up.valid && up.ready;
  assign dn.valid = v_r;
  assign dn.data  = d_r;

  assign rem_w = W'(up.data.rem);
  assign div_w = W'(up.data.n) << SHIFT;

  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    if (load) begin
      v_nxt = 1'b1;
      d_nxt = up.data;
      if (rem_w >= div_w) begin
        d_nxt.rem = up.data.rem - div_w[sbtm_pkg::TRACK_W-1:0];
      end
    end else if (dn.ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

endmodule

FILE: rtl/sbtm_base.sv
// ----------------------------------------------------------------------------
// sbtm_base: base track selection
// Applies the configured pattern to the side pair and reduced track.
// ----------------------------------------------------------------------------
module sbtm_base (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   pattern,
  input  logic [sbtm_pkg::FLEX_W-1:0]  flexibility,
  sbtm_stream_if.sink                  up,
  sbtm_stream_if.source                dn
);

  localparam int VW = sbtm_pkg::COUNT_W + 1;

  logic                              v_r, v_nxt;
  sbtm_pkg::job_t                    d_r, d_nxt;
  logic                              load;
  logic [1:0]                        s, d, cw, ccw, opp, straight, mirror;
  logic                              horiz;
  logic [VW-1:0]                     t, n, v, vr;
  logic                              ok;
  logic [sbtm_pkg::FLEX_W-1:0]       fs;
  logic [sbtm_pkg::DIV3_W-1:0]       prod;
  logic [sbtm_pkg::STEP_W-1:0]       step;

  assign up.ready = !v_r || dn.ready;
  assign load     = up.valid && up.ready;
  assign dn.valid = v_r;
  assign dn.data  = d_r;

  assign s = up.data.source_side;
  assign d = up.data.dest_side;
  assign t = VW'(up.data.rem);
  assign n = VW'(up.data.n);

  assign cw       = s + 2'd1;
  assign ccw      = s + 2'd3;
  assign opp      = s + 2'd2;
  assign horiz    = (s == sbtm_pkg::SIDE_LEFT) || (s == sbtm_pkg::SIDE_RIGHT);
  assign straight = horiz ? ccw : cw;
  assign mirror   = horiz ? cw : ccw;

  // every candidate stays below 2n, so one conditional subtract reduces it
  always_comb begin
    v  = t;
    ok = 1'b0;
    case (pattern)
      sbtm_pkg::PAT_SUBSET: begin
        ok = 1'b1;
      end
      sbtm_pkg::PAT_UNIVERSAL: begin
        if (s != d) begin
          if (d == opp || d == straight) begin
            ok = 1'b1;
          end else if (d == mirror) begin
            ok = 1'b1;
            v  = n - VW'(1) - t;
          end
        end
      end
      sbtm_pkg::PAT_WILTON: begin
        ok = 1'b1;
        case ({s, d})
          {sbtm_pkg::SIDE_LEFT,   sbtm_pkg::SIDE_RIGHT}:  v = t;
          {sbtm_pkg::SIDE_LEFT,   sbtm_pkg::SIDE_TOP}:    v = n - t;
          {sbtm_pkg::SIDE_LEFT,   sbtm_pkg::SIDE_BOTTOM}: v = t + n - VW'(1);
          {sbtm_pkg::SIDE_RIGHT,  sbtm_pkg::SIDE_LEFT}:   v = t;
          {sbtm_pkg::SIDE_RIGHT,  sbtm_pkg::SIDE_TOP}:    v = t + n - VW'(1);
          {sbtm_pkg::SIDE_RIGHT,  sbtm_pkg::SIDE_BOTTOM}: v = (n << 1) - VW'(2) - t;
          {sbtm_pkg::SIDE_BOTTOM, sbtm_pkg::SIDE_TOP}:    v = t;
          {sbtm_pkg::SIDE_BOTTOM, sbtm_pkg::SIDE_LEFT}:   v = t + VW'(1);
          {sbtm_pkg::SIDE_BOTTOM, sbtm_pkg::SIDE_RIGHT}:  v = (n << 1) - VW'(2) - t;
          {sbtm_pkg::SIDE_TOP,    sbtm_pkg::SIDE_BOTTOM}: v = t;
          {sbtm_pkg::SIDE_TOP,    sbtm_pkg::SIDE_LEFT}:   v = n - t;
          {sbtm_pkg::SIDE_TOP,    sbtm_pkg::SIDE_RIGHT}:  v = t + VW'(1);
          default:                                        ok = 1'b0;
        endcase
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (n == '0) begin
      ok = 1'b0;
    end
  end

  assign vr = (v >= n) ? v - n : v;

  // clamp Fs, then divide by three
  always_comb begin
    if (flexibility < sbtm_pkg::FLEX_W'(3)) begin
      fs = sbtm_pkg::FLEX_W'(3);
    end else if (flexibility > sbtm_pkg::FLEX_W'(sbtm_pkg::MAX_FLEX)) begin
      fs = sbtm_pkg::FLEX_W'(sbtm_pkg::MAX_FLEX);
    end else begin
      fs = flexibility;
    end
  end

  assign prod = sbtm_pkg::DIV3_W'(fs) * sbtm_pkg::DIV3_W'(sbtm_pkg::DIV3_MUL);

  // 3 mod n for the stride between results
  always_comb begin
    case (up.data.n)
      sbtm_pkg::COUNT_W'(1): step = 2'd0;
      sbtm_pkg::COUNT_W'(2): step = 2'd1;
      sbtm_pkg::COUNT_W'(3): step = 2'd0;
      default:               step = 2'd3;
    endcase
  end

  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    if (load) begin
      v_nxt = 1'b1;
      d_nxt.n    = up.data.n;
      d_nxt.step = step;
      if (ok) begin
        d_nxt.base          = vr[sbtm_pkg::TRACK_W-1:0];
        d_nxt.runs          = prod[sbtm_pkg::DIV3_SHIFT +: sbtm_pkg::RUNS_W];
        d_nxt.no_connection = 1'b0;
      end else begin
        d_nxt.base          = '0;
        d_nxt.runs          = sbtm_pkg::RUNS_W'(1);
        d_nxt.no_connection = 1'b1;
      end
    end else if (dn.ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

endmodule

FILE: rtl/sbtm_emit.sv
// ----------------------------------------------------------------------------
// sbtm_emit: result sequencer and output register
// Walks base, base+3, ... mod n, one result word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sbtm_emit (
  input  logic           clk,
  input  logic           rst_n,
  sbtm_stream_if.sink    up,
  sbtm_stream_if.source  dn
);

  logic                   have_r, have_nxt;
  sbtm_pkg::job_t         job_r, job_nxt;
  logic                   ov_r, ov_nxt;
  sbtm_pkg::out_word_t    od_r, od_nxt;
  logic                   out_free, fire, final_one, load;
  logic [sbtm_pkg::COUNT_W-1:0] sum;

  assign out_free  = !ov_r || dn.ready;
  assign fire      = have_r && out_free;
  assign final_one = (job_r.runs == sbtm_pkg::RUNS_W'(1));
  assign up.ready  = !have_r || (fire && final_one);
  assign load      = up.valid && up.ready;
  assign dn.valid  = ov_r;
  assign dn.data   = od_r;

  assign sum = sbtm_pkg::COUNT_W'(job_r.base) + sbtm_pkg::COUNT_W'(job_r.step);

  always_comb begin
    have_nxt = have_r;
    job_nxt  = job_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    if (fire) begin
      ov_nxt               = 1'b1;
      od_nxt.dest_track    = job_r.base;
      od_nxt.no_connection = job_r.no_connection;
      od_nxt.last          = final_one;
      // advance to the next track of the run
      job_nxt.runs = job_r.runs - sbtm_pkg::RUNS_W'(1);
      if (sum >= job_r.n) begin
        job_nxt.base = sbtm_pkg::TRACK_W'(sum - job_r.n);
      end else begin
        job_nxt.base = sum[sbtm_pkg::TRACK_W-1:0];
      end
      if (final_one) begin
        have_nxt = 1'b0;
      end
    end else if (dn.ready) begin
      ov_nxt = 1'b0;
    end
    if (load) begin
      have_nxt = 1'b1;
      job_nxt  = up.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      have_r <= have_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    od_r  <= od_nxt;
  end

endmodule

FILE: rtl/switch_block_track_mapper.sv
// Takes one word per cycle while the modulo chain is not stalled and returns floor(Fs/3) result
// words per accepted word, Fs clamped to 3..48 (one no-connection word when the side pair does
// not connect), one result per cycle while the output is not stalled, so a word holds the result
// sequencer for all its results, which sets the sustained rate. Ten modulo cells reduce the source
// track mod the destination count one quotient bit each, one stage picks the base track, and the
// sequencer loads the output register. Write configuration only while no word is in flight.
// ----------------------------------------------------------------------------
// switch_block_track_mapper: switch block destination track lister
// Chain of modulo cells, base selection stage and result sequencer.
// ----------------------------------------------------------------------------
module switch_block_track_mapper (
  input  logic          clk,
  input  logic          rst_n,
  sbtm_stream_if.sink   in_ch,
  sbtm_stream_if.source out_ch,
  sbtm_stream_if.sink   cfg_ch
);

  localparam int CELLS = sbtm_pkg::TRACK_W;

  logic [1:0]                  pattern_r, pattern_nxt;
  logic [sbtm_pkg::FLEX_W-1:0] flex_r, flex_nxt;
  logic [sbtm_pkg::COUNT_W-1:0] n_sat;

  sbtm_stream_if #(.T(sbtm_pkg::cell_word_t)) link [0:CELLS] ();
  sbtm_stream_if #(.T(sbtm_pkg::job_t))       job_ch ();

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    pattern_nxt = pattern_r;
    flex_nxt    = flex_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.data.reg_index)
        sbtm_pkg::CFG_PATTERN: pattern_nxt = cfg_ch.data.wdata[1:0];
        sbtm_pkg::CFG_FLEX:    flex_nxt    = cfg_ch.data.wdata;
        default:               ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= sbtm_pkg::PATTERN_RST;
      flex_r    <= sbtm_pkg::FLEX_RST;
    end else begin
      pattern_r <= pattern_nxt;
      flex_r    <= flex_nxt;
    end
  end

  // saturate the count and enter the modulo chain
  assign n_sat = (in_ch.data.dest_count > sbtm_pkg::COUNT_W'(sbtm_pkg::MAX_TRACKS)) ?
                 sbtm_pkg::COUNT_W'(sbtm_pkg::MAX_TRACKS) : in_ch.data.dest_count;

  assign link[0].valid            = in_ch.valid;
  assign link[0].data.source_side = in_ch.data.source_side;
  assign link[0].data.dest_side   = in_ch.data.dest_side;
  assign link[0].data.n           = n_sat;
  assign link[0].data.rem         = in_ch.data.source_track;
  assign in_ch.ready              = link[0].ready;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    sbtm_mod_cell #(.SHIFT(CELLS - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .up    (link[i]),
      .dn    (link[i+1])
    );
  end

  sbtm_base u_base (
    .clk         (clk),
    .rst_n       (rst_n),
    .pattern     (pattern_r),
    .flexibility (flex_r),
    .up          (link[CELLS]),
    .dn          (job_ch)
  );

  sbtm_emit u_emit (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (job_ch),
    .dn    (out_ch)
  );

  // no-connection words stand alone and point at track zero
  a_nc_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.no_connection |->
      out_ch.data.last && (out_ch.data.dest_track == '0))
    else $error("no-connection word not marked last");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !job_ch.valid)
    else $error("result side busy after reset");

  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    job_ch.valid && !job_ch.ready |=> job_ch.valid && $stable(job_ch.data))
    else $error("job dropped while sequencer busy");

endmodule
